### rtl/cld_pkg.sv
// Shared types, codes and constants for the content-length deframer.
package cld_pkg;

	localparam int DEFAULT_LENGTH_BITS = 24;
	localparam int PREFIX_LEN = 16;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_CR     = 2'd1;
	localparam logic [1:0] PH_LF     = 2'd2;
	localparam logic [1:0] PH_BODY   = 2'd3;

	localparam logic [1:0] KIND_BODY  = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_EOF_HEADER = 3'd1;
	localparam logic [2:0] ERR_SEPARATOR  = 3'd2;
	localparam logic [2:0] ERR_EOF_BODY   = 3'd3;
	localparam logic [2:0] ERR_PREFIX     = 3'd4;
	localparam logic [2:0] ERR_TOO_LONG   = 3'd5;

	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
		logic [7:0] body_byte;
		logic       last;
		logic [2:0] error_code;
	} cld_result_t;

	function automatic logic [7:0] prefix_char(input logic [3:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0: ch = 8'h43;
			4'd1: ch = 8'h6F;
			4'd2: ch = 8'h6E;
			4'd3: ch = 8'h74;
			4'd4: ch = 8'h65;
			4'd5: ch = 8'h6E;
			4'd6: ch = 8'h74;
			4'd7: ch = 8'h2D;
			4'd8: ch = 8'h4C;
			4'd9: ch = 8'h65;
			4'd10: ch = 8'h6E;
			4'd11: ch = 8'h67;
			4'd12: ch = 8'h74;
			4'd13: ch = 8'h68;
			4'd14: ch = 8'h3A;
			4'd15: ch = 8'h20;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

### rtl/cld_parser.sv
// Header and body state tracking; one word per step, at most one result.
module cld_parser
	import cld_pkg::*;
#(
	parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  data_byte,
	input  logic        end_of_input,
	output cld_result_t result
);

	localparam int EXT_BITS = LENGTH_BITS + 4;

	logic [1:0]             phase_q, phase_n;
	logic [4:0]             prefix_pos_q, prefix_pos_n;
	logic                   prefix_bad_q, prefix_bad_n;
	logic                   saw_cr_q, saw_cr_n;
	logic                   number_done_q, number_done_n;
	logic                   length_overflow_q, length_overflow_n;
	logic [LENGTH_BITS-1:0] length_value_q, length_value_n;
	logic [LENGTH_BITS-1:0] bytes_left_q, bytes_left_n;
	logic                   clear;

	logic                   is_digit;
	logic [EXT_BITS-1:0]    len_ext;
	logic [EXT_BITS-1:0]    len_next;
	logic                   len_ovf;

	assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
	assign len_ext  = {4'b0000, length_value_q};
	assign len_next = (len_ext << 3) + (len_ext << 1)
		+ {{(EXT_BITS-4){1'b0}}, data_byte[3:0]};
	assign len_ovf  = |len_next[EXT_BITS-1:LENGTH_BITS];

	always_comb begin
		phase_n           = phase_q;
		prefix_pos_n      = prefix_pos_q;
		prefix_bad_n      = prefix_bad_q;
		saw_cr_n          = saw_cr_q;
		number_done_n     = number_done_q;
		length_overflow_n = length_overflow_q;
		length_value_n    = length_value_q;
		bytes_left_n      = bytes_left_q;
		clear             = 1'b0;
		result            = '0;
		case (phase_q)
			PH_HEADER: begin
				if (end_of_input) begin
					clear             = 1'b1;
					result.valid      = 1'b1;
					result.kind       = KIND_ERROR;
					result.error_code = ERR_EOF_HEADER;
				end else if (saw_cr_q && data_byte == CH_LF) begin
					if (prefix_bad_q || prefix_pos_q < 5'(PREFIX_LEN)) begin
						clear             = 1'b1;
						result.valid      = 1'b1;
						result.kind       = KIND_ERROR;
						result.error_code = ERR_PREFIX;
					end else if (length_overflow_q) begin
						clear             = 1'b1;
						result.valid      = 1'b1;
						result.kind       = KIND_ERROR;
						result.error_code = ERR_TOO_LONG;
					end else begin
						phase_n = PH_CR;
					end
				end else begin
					if (data_byte == CH_CR) begin
						saw_cr_n = 1'b1;
					end
					if (prefix_pos_q < 5'(PREFIX_LEN)) begin
						if (data_byte != prefix_char(prefix_pos_q[3:0])) begin
							prefix_bad_n = 1'b1;
						end
						prefix_pos_n = prefix_pos_q + 5'd1;
					end else if (!number_done_q) begin
						if (is_digit) begin
							if (!length_overflow_q) begin
								if (len_ovf) begin
									length_overflow_n = 1'b1;
								end else begin
									length_value_n = len_next[LENGTH_BITS-1:0];
								end
							end
						end else begin
							number_done_n = 1'b1;
						end
					end
				end
			end
			PH_CR: begin
				if (end_of_input || data_byte != CH_CR) begin
					clear             = 1'b1;
					result.valid      = 1'b1;
					result.kind       = KIND_ERROR;
					result.error_code = ERR_SEPARATOR;
				end else begin
					phase_n = PH_LF;
				end
			end
			PH_LF: begin
				if (end_of_input || data_byte != CH_LF) begin
					clear             = 1'b1;
					result.valid      = 1'b1;
					result.kind       = KIND_ERROR;
					result.error_code = ERR_SEPARATOR;
				end else if (length_value_q == '0) begin
					clear        = 1'b1;
					result.valid = 1'b1;
					result.kind  = KIND_EMPTY;
					result.last  = 1'b1;
				end else begin
					bytes_left_n = length_value_q;
					phase_n      = PH_BODY;
				end
			end
			default: begin
				if (end_of_input) begin
					clear             = 1'b1;
					result.valid      = 1'b1;
					result.kind       = KIND_ERROR;
					result.error_code = ERR_EOF_BODY;
				end else begin
					result.valid     = 1'b1;
					result.kind      = KIND_BODY;
					result.body_byte = data_byte;
					if (bytes_left_q <= LENGTH_BITS'(1)) begin
						clear       = 1'b1;
						result.last = 1'b1;
					end else begin
						bytes_left_n = bytes_left_q - LENGTH_BITS'(1);
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= PH_HEADER;
			prefix_pos_q      <= '0;
			prefix_bad_q      <= 1'b0;
			saw_cr_q          <= 1'b0;
			number_done_q     <= 1'b0;
			length_overflow_q <= 1'b0;
			length_value_q    <= '0;
			bytes_left_q      <= '0;
		end else if (step) begin
			if (clear) begin
				phase_q           <= PH_HEADER;
				prefix_pos_q      <= '0;
				prefix_bad_q      <= 1'b0;
				saw_cr_q          <= 1'b0;
				number_done_q     <= 1'b0;
				length_overflow_q <= 1'b0;
				length_value_q    <= '0;
				bytes_left_q      <= '0;
			end else begin
				phase_q           <= phase_n;
				prefix_pos_q      <= prefix_pos_n;
				prefix_bad_q      <= prefix_bad_n;
				saw_cr_q          <= saw_cr_n;
				number_done_q     <= number_done_n;
				length_overflow_q <= length_overflow_n;
				length_value_q    <= length_value_n;
				bytes_left_q      <= bytes_left_n;
			end
		end
	end

	a_body_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> bytes_left_q != '0)
		else $error("body phase with no bytes left");

	a_prefix_sat: assert property (@(posedge clk) disable iff (!arst_n)
		prefix_pos_q <= 5'(PREFIX_LEN))
		else $error("prefix position past prefix length");

	a_no_early_digits: assert property (@(posedge clk) disable iff (!arst_n)
		prefix_pos_q < 5'(PREFIX_LEN) |-> !number_done_q && length_value_q == '0)
		else $error("length digits taken inside the prefix");

endmodule

### rtl/content_length_deframer_top.sv
// Top level of the content-length deframer: input stage, parser and result register.
//
// Input channel: in_valid/in_ready carry one word per item, data_byte plus
// end_of_input (data_byte is ignored when end_of_input is set).
// Output channel: out_valid/out_ready carry one result: kind (body byte,
// empty message, error), body_byte, last and error_code.
// Each header word yields no result unless it raises an error; each body word
// yields one body byte, the final one with last set. A zero length gives one
// empty-message result; an error gives one error result and the parser starts over.
// A word is registered in the input stage at acceptance, and its result is
// registered in the result register when the parser steps on that word.
// Throughput: one word per cycle while no result waits on out_ready, set by
// the combinational parser update between the input and result registers.
// When out_ready is low with a result waiting, the input stage holds one
// word and in_ready drops once that stage is full.
// Reset (arst_n low) clears both stages and returns the parser to the
// start of a header; no result is pending after reset.
module content_length_deframer_top
	import cld_pkg::*;
#(
	parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       end_of_input,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] body_byte,
	output logic       last,
	output logic [2:0] error_code
);

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        eof_s1;
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  body_byte_q;
	logic        last_q;
	logic [2:0]  error_code_q;
	logic        advance;
	logic        step;
	cld_result_t res;

	assign advance  = !out_valid_q || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
			eof_s1  <= end_of_input;
		end
	end

	cld_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.data_byte    (data_s1),
		.end_of_input (eof_s1),
		.result       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			kind_q       <= res.kind;
			body_byte_q  <= res.body_byte;
			last_q       <= res.last;
			error_code_q <= res.error_code;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign body_byte  = body_byte_q;
	assign last       = last_q;
	assign error_code = error_code_q;

	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == KIND_ERROR |-> !last_q && error_code_q != ERR_NONE)
		else $error("error result with last set or no code");

	a_code_only_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q != KIND_ERROR |-> error_code_q == ERR_NONE)
		else $error("error code on a non-error result");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == KIND_EMPTY |-> last_q && body_byte_q == 8'h00)
		else $error("empty message without last");

endmodule
